### rtl/core/brm_pkg.sv
// brm_pkg: shared types and constants of the block rms meter
// no dependencies; used by the controller, the datapath and the top level

package brm_pkg;

  localparam int SUM_W               = 48;
  localparam int RMS_W               = 16;
  localparam int MAX_SAMPLES_DEFAULT = 65536;
  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int STEP_W              = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } brm_state_t;

  typedef struct packed {
    logic acc;
    logic div_load;
    logic div_step;
    logic sqrt_clear;
    logic sqrt_step;
    logic out_load;
  } brm_cmd_t;

  typedef struct packed {
    logic out_free;
  } brm_status_t;

endpackage

### rtl/core/brm_ctrl.sv
// brm_ctrl: sequencer for accumulate, divide, square root and result hand-off
// depends on brm_pkg

module brm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  last,
  input  brm_pkg::brm_status_t  status,
  output logic                  in_stall,
  output brm_pkg::brm_cmd_t     cmd
);

  localparam int SW = brm_pkg::SUM_W;
  localparam int RW = brm_pkg::SUM_W / 2;

  brm_pkg::brm_state_t          state, state_next;
  logic [brm_pkg::STEP_W-1:0]   step;
  logic                         step_div_end, step_sqrt_end;

  assign step_div_end  = (step == brm_pkg::STEP_W'(SW - 1));
  assign step_sqrt_end = (step == brm_pkg::STEP_W'(RW - 1));

  always_comb begin
    state_next = state;
    case (state)
      brm_pkg::ST_ACC: begin
        if (in_valid && last) state_next = brm_pkg::ST_DIV;
      end
      brm_pkg::ST_DIV: begin
        if (step_div_end) state_next = brm_pkg::ST_SQRT;
      end
      brm_pkg::ST_SQRT: begin
        if (step_sqrt_end) state_next = brm_pkg::ST_EMIT;
      end
      brm_pkg::ST_EMIT: begin
        if (status.out_free) state_next = brm_pkg::ST_ACC;
      end
      default: state_next = brm_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    cmd            = '0;
    case (state)
      brm_pkg::ST_ACC: begin
        in_stall     = 1'b0;
        cmd.acc      = in_valid;
        cmd.div_load = in_valid && last;
      end
      brm_pkg::ST_DIV: begin
        cmd.div_step   = 1'b1;
        cmd.sqrt_clear = step_div_end;
      end
      brm_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
      end
      brm_pkg::ST_EMIT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brm_pkg::ST_ACC;
      step  <= '0;
    end else begin
      state <= state_next;
      // step count restarts on every state change
      if (state_next != state) step <= '0;
      else                     step <= step + 1'b1;
    end
  end

endmodule

### rtl/core/brm_datapath.sv
// brm_datapath: square and accumulate, restoring divider, digit-by-digit root,
// output register; depends on brm_pkg, driven by brm_ctrl commands

module brm_datapath #(
  parameter int MAX_SAMPLES = brm_pkg::MAX_SAMPLES_DEFAULT,
  parameter int SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  brm_pkg::brm_cmd_t             cmd,
  input  logic                          out_stall,
  output brm_pkg::brm_status_t          status,
  output logic                          out_valid,
  output logic [brm_pkg::RMS_W-1:0]     rms,
  output logic                          overflow
);

  localparam int SW = brm_pkg::SUM_W;
  localparam int RW = brm_pkg::SUM_W / 2;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int QW = brm_pkg::RMS_W;

  // accumulator
  logic [SW-1:0]              square_sum, sum_next;
  logic [CW-1:0]              sample_count, count_next;
  logic                       overflowed, ovf_next, full;
  logic [SAMPLE_BITS-1:0]     mag;
  logic [2*SAMPLE_BITS-1:0]   sq;
  logic [SW:0]                sum_ext;

  // divider and root
  logic [SW-1:0]              quo;
  logic [CW:0]                rem, rem_sh;
  logic [CW-1:0]              den;
  logic                       div_ge, ovf_hold, zero_den;
  logic [RW+1:0]              sq_rem, rem_t, trial;
  logic [RW-1:0]              root;
  logic                       sqrt_ge;

  assign full = (sample_count >= CW'(MAX_SAMPLES));

  always_comb begin
    mag     = sample[SAMPLE_BITS-1] ? (~$unsigned(sample) + 1'b1) : $unsigned(sample);
    sq      = mag * mag;
    sum_ext = {1'b0, square_sum} + (SW+1)'(sq);
    if (full) begin
      sum_next   = square_sum;
      count_next = sample_count;
    end else begin
      sum_next   = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
      count_next = sample_count + 1'b1;
    end
    ovf_next = overflowed | full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
      overflowed   <= 1'b0;
    end else if (cmd.div_load) begin
      square_sum   <= '0;
      sample_count <= '0;
      overflowed   <= 1'b0;
    end else if (cmd.acc) begin
      square_sum   <= sum_next;
      sample_count <= count_next;
      overflowed   <= ovf_next;
    end
  end

  // one quotient bit per cycle, dividend shifts out of quo as quotient shifts in
  assign rem_sh = {rem[CW-1:0], quo[SW-1]};
  assign div_ge = (rem_sh >= {1'b0, den});

  // two radicand bits per cycle, taken from the top of the quotient
  assign rem_t   = {sq_rem[RW-1:0], quo[SW-1:SW-2]};
  assign trial   = {root, 2'b01};
  assign sqrt_ge = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo      <= sum_next;
      rem      <= '0;
      den      <= count_next;
      ovf_hold <= ovf_next;
      zero_den <= (count_next == '0);
    end else if (cmd.div_step) begin
      rem <= div_ge ? (rem_sh - {1'b0, den}) : rem_sh;
      quo <= {quo[SW-2:0], div_ge};
    end else if (cmd.sqrt_step) begin
      quo <= {quo[SW-3:0], 2'b00};
    end

    if (cmd.sqrt_clear) begin
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_rem <= sqrt_ge ? (rem_t - trial) : rem_t;
      root   <= {root[RW-2:0], sqrt_ge};
    end

    if (cmd.out_load) begin
      if (zero_den)               rms <= '0;
      else if (|root[RW-1:QW])    rms <= '1;
      else                        rms <= root[QW-1:0];
      overflow <= ovf_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule

### rtl/core/block_rms_meter_unit.sv
// block_rms_meter_unit: top level of the block rms meter
// depends on brm_pkg, brm_ctrl and brm_datapath
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+---------------------------
//  in      | in_valid, in_stall, sample, last | in_valid && !in_stall
//  out     | out_valid, out_stall, rms,       | out_valid && !out_stall
//          | overflow                         |
//
// one sample per cycle while a block is accumulating (multiply and add are combinational ahead of the sum register)
// a last sample closes the block: the divider steps, the root steps and the load state
// follow, in_stall high throughout
// the load state stretches while the previous result still sits stalled in the
// output register; a held result delays this block's hand-off and with it the next
// block's accumulation
// rst is synchronous and clears sum, count, flag, sequencer and out_valid

module block_rms_meter_unit #(
  parameter int MAX_SAMPLES = brm_pkg::MAX_SAMPLES_DEFAULT,
  parameter int SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brm_pkg::RMS_W-1:0]     rms,
  output logic                          overflow
);

  brm_pkg::brm_cmd_t    cmd;
  brm_pkg::brm_status_t status;

  brm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  brm_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .rms       (rms),
    .overflow  (overflow)
  );

endmodule

### rtl/core/brm_checker.sv
// brm_props: port-level checks of block_rms_meter_unit
// depends on brm_pkg; attached to the top level by the bind below

module brm_props (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      last,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [brm_pkg::RMS_W-1:0] rms,
  input logic                      overflow
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rms) && $stable(overflow))
    else $error("result changed while stalled");

  // closing a block stops sample intake
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("sample taken right after last transfer");

  // a new result is loaded only while intake is stalled
  a_load_stalled: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while accumulating");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind block_rms_meter_unit brm_props u_brm_props (.*);

### tb/brm_checker.sv
// brm_checker: watches the sample and reading channels of the block rms meter,
// predicts each reading and compares it field by field; depends on brm_pkg

module brm_checker #(
  parameter int MAX_SAMPLES = brm_pkg::MAX_SAMPLES_DEFAULT,
  parameter int SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic                           last,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [brm_pkg::RMS_W-1:0]      rms,
  input  logic                           overflow,
  output int                             mismatches,
  output int                             readings_due
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUM_W   = brm_pkg::SUM_W;
  localparam int RMS_W   = brm_pkg::RMS_W;
  localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int ROOT_W  = SUM_W / 2;

  typedef struct packed {
    logic [RMS_W-1:0] level;
    logic             clipped;
  } reading_t;

  reading_t           due_q[$];
  logic [SUM_W-1:0]   energy;
  logic [COUNT_W-1:0] n_held;
  logic               dropped;

  function automatic logic [ROOT_W-1:0] floor_sqrt(logic [SUM_W-1:0] v);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] trial;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = r | (ROOT_W'(1) << b);
      if (SUM_W'(trial) * SUM_W'(trial) <= v) r = trial;
    end
    return r;
  endfunction

  function automatic void take_sample(logic signed [SAMPLE_BITS-1:0] s, logic closes);
    logic signed [SAMPLE_BITS:0] wide;
    logic [SAMPLE_BITS:0]        mag;
    logic [SUM_W:0]              total;
    logic [SUM_W-1:0]            mean;
    logic [ROOT_W-1:0]           root;
    reading_t                    r;
    if (n_held >= MAX_SAMPLES) begin
      // block too long: sample dropped, flag sticks until the block closes
      dropped = 1'b1;
    end else begin
      wide   = s;
      mag    = (wide < 0) ? -wide : wide;
      total  = {1'b0, energy} + (SUM_W+1)'(mag) * (SUM_W+1)'(mag);
      energy = total[SUM_W] ? '1 : total[SUM_W-1:0];
      n_held = n_held + 1'b1;
    end
    if (closes) begin
      mean      = (n_held == 0) ? '0 : energy / SUM_W'(n_held);
      root      = floor_sqrt(mean);
      r.level   = ((root >> RMS_W) != 0) ? '1 : root[RMS_W-1:0];
      r.clipped = dropped;
      due_q.push_back(r);
      energy  = '0;
      n_held  = '0;
      dropped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    if (rst) begin
      energy  = '0;
      n_held  = '0;
      dropped = 1'b0;
      due_q.delete();
    end else begin
      // results lag their samples, so retire before predicting
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: reading rms=%0d overflow=%0b arrived with none due",
                     $time, rms, overflow);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          if (rms !== want.level || overflow !== want.clipped) begin
            if (mismatches < 10)
              $display("%0t: reading mismatch rms exp %0d got %0d, overflow exp %0b got %0b",
                       $time, want.level, rms, want.clipped, overflow);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) take_sample(sample, last);
    end
    readings_due = due_q.size();
  end

endmodule

### tb/testbench.sv
// testbench: drives sample blocks into block_rms_meter_unit and gives the verdict
// depends on brm_pkg, block_rms_meter_unit and brm_checker

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = brm_pkg::SAMPLE_BITS_DEFAULT;
  localparam int RAND_ITEMS = 530;
  localparam int HOLD_LEN   = 400;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [brm_pkg::RMS_W-1:0]  rms;
  logic                       overflow;
  int                         mismatches;
  int                         readings_due;

  // shared knobs, written by the sender only
  bit steady      = 1'b0;
  bit stall_burst = 1'b0;

  always #5 clk = ~clk;

  block_rms_meter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rms       (rms),
    .overflow  (overflow)
  );

  brm_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rms          (rms),
    .overflow     (overflow),
    .mismatches   (mismatches),
    .readings_due (readings_due)
  );

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic put_sample(input logic signed [SAMPLE_W-1:0] s, input logic closes);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    last     <= closes;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_block(input logic signed [SAMPLE_W-1:0] vals[$]);
    foreach (vals[i]) put_sample(vals[i], i == vals.size() - 1);
  endtask

  task automatic long_block(input int len);
    for (int k = 1; k <= len; k++) put_sample(pick_sample(), k == len);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (readings_due == 0);
    @(negedge clk);
  endtask

  initial begin : receiver
    int held;
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_burst && !held_off) begin
        // long hold-off so a finished block waits behind the output register and intake stalls
        held_off = 1'b1;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_LEN; held++) @(negedge clk);
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 36);
      end
    end
  end

  initial begin : stimulus
    int blk;
    int len;
    int sent;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-sample blocks at the extremes, then small mixed blocks
    send_block('{16'h0000});
    send_block('{16'h8000});
    send_block('{16'h7FFF});
    send_block('{16'hFFFF});
    send_block('{16'h0001, 16'hFFFF, 16'h0000});
    send_block('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    send_block('{16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0});
    send_block('{16'sd100, -16'sd200, 16'sd300, -16'sd400, 16'sd500});
    drain();

    blk  = 0;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      blk++;
      if (blk == 8) stall_burst = 1'b1;
      steady = (blk >= 30 && blk < 38);
      if (blk >= 8 && blk < 16)
        len = $urandom_range(1, 3);
      else if ($urandom_range(9) < 8)
        len = $urandom_range(1, 12);
      else
        len = $urandom_range(13, 80);
      long_block(len);
      sent += len;
      if (blk == 45) drain();
    end
    steady = 1'b0;
    drain();
    repeat (100) @(posedge clk);

    if (mismatches == 0 && readings_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
